// ===== rtl/i2d_pkg.sv =====
// Shared types, constants and the decimal weight table for the converter.
`timescale 1ns / 1ps

package i2d_pkg;

    localparam int MAG_W      = 32;
    localparam int THR_W      = MAG_W + 2;
    localparam int NUM_DIGITS = 10;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_DIGITS - 1);
    localparam logic [7:0]       CHAR_MINUS = 8'h2D;
    localparam logic [7:0]       CHAR_ZERO  = 8'h30;

    typedef struct packed {
        logic [MAG_W-1:0] value;
        logic             signed_mode;
    } in_req_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } out_req_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } job_t;

    function automatic logic [THR_W-1:0] dec_weight(input logic [IDX_W-1:0] idx);
        logic [THR_W-1:0] w;
        unique case (idx)
            4'd0:    w = THR_W'(1000000000);
            4'd1:    w = THR_W'(100000000);
            4'd2:    w = THR_W'(10000000);
            4'd3:    w = THR_W'(1000000);
            4'd4:    w = THR_W'(100000);
            4'd5:    w = THR_W'(10000);
            4'd6:    w = THR_W'(1000);
            4'd7:    w = THR_W'(100);
            4'd8:    w = THR_W'(10);
            4'd9:    w = THR_W'(1);
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/int32_to_decimal_ascii_core.sv =====
// Top level of the 32-bit binary to decimal ASCII converter.
// Request channel: req_valid/req_stall carry req_data = {value, signed_mode}.
// A request is taken on a clock edge with req_valid high and req_stall low.
// Character channel: chr_valid/chr_stall carry chr_data = {char_code, last},
// most significant character first; last marks the final character of a value.
// Signed mode with the top bit set gives '-' and then the full 32-bit magnitude.
// Leading zeros are dropped; zero gives a single '0'.
// A request passes through the job queue and the serializer registers before its
// first character, sign or digit, reaches the output register. The serializer
// takes a step for the sign, if any, and one for each of the ten decimal weights,
// suppressed leading zeros included, whatever the number of digits printed.
// The next queued value loads in the same cycle as the last digit step.
// A two-entry job queue sits between front end and serializer, so requests
// keep being taken while the serializer works or waits on chr_stall.
// While a valid character is stalled by chr_stall the output register holds it
// and the serializer waits; once the queue is full req_stall rises.
// Reset (rst_n low, asynchronous) empties the queue and drops any value in
// progress; no character is valid afterwards until a new request arrives.
`timescale 1ns / 1ps

module int32_to_decimal_ascii_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  i2d_pkg::in_req_t  req_data,
    output logic              chr_valid,
    input  logic              chr_stall,
    output i2d_pkg::out_req_t chr_data
);
    import i2d_pkg::*;

    logic push;
    logic pop;
    logic fifo_full;
    logic fifo_nonempty;
    job_t push_job;
    job_t pop_job;

    i2d_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .push      (push),
        .push_job  (push_job),
        .fifo_full (fifo_full)
    );

    i2d_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (fifo_full),
        .nonempty (fifo_nonempty)
    );

    i2d_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_nonempty (fifo_nonempty),
        .pop_job       (pop_job),
        .pop           (pop),
        .chr_valid     (chr_valid),
        .chr_stall     (chr_stall),
        .chr_data      (chr_data)
    );

endmodule

// ===== rtl/i2d_front.sv =====
// Front end: takes requests, splits them into sign and 32-bit magnitude.
`timescale 1ns / 1ps

module i2d_front (
    input  logic           req_valid,
    output logic           req_stall,
    input  i2d_pkg::in_req_t req_data,
    output logic           push,
    output i2d_pkg::job_t  push_job,
    input  logic           fifo_full
);
    import i2d_pkg::*;

    logic negative;

    assign negative      = req_data.signed_mode & req_data.value[MAG_W-1];
    assign req_stall     = fifo_full;
    assign push          = req_valid & ~fifo_full;
    assign push_job.neg  = negative;
    assign push_job.mag  = negative ? (~req_data.value + MAG_W'(1)) : req_data.value;

endmodule

// ===== rtl/i2d_fifo.sv =====
// Short job queue between front end and digit serializer.
`timescale 1ns / 1ps

module i2d_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  i2d_pkg::job_t push_job,
    input  logic          pop,
    output i2d_pkg::job_t pop_job,
    output logic          full,
    output logic          nonempty
);
    import i2d_pkg::*;

    job_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(FIFO_DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_job  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && nonempty))
            count_next = count_reg + CNT_W'(1);
        else if (!push && pop && nonempty)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            if (pop && nonempty)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/i2d_back.sv =====
// Back end: one digit per cycle unless stalled, drops leading 0s, output register.
`timescale 1ns / 1ps

module i2d_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fifo_nonempty,
    input  i2d_pkg::job_t   pop_job,
    output logic            pop,
    output logic            chr_valid,
    input  logic            chr_stall,
    output i2d_pkg::out_req_t chr_data
);
    import i2d_pkg::*;

    logic             active_reg;
    logic             neg_pending_reg;
    logic             started_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    out_req_t         out_data_reg;

    logic [THR_W-1:0] weight;
    logic [THR_W-1:0] thr [10];
    logic [3:0]       digit;
    logic [MAG_W-1:0] remainder;
    logic             out_free;
    logic             step;
    logic             emit_digit;
    logic             finishing;
    logic             load;

    assign weight = dec_weight(idx_reg);

    always_comb
    begin
        digit = '0;
        for (int m = 0; m < 10; m++)
        begin
            thr[m] = THR_W'(m) * weight;
            if (m != 0 && {2'b00, mag_reg} >= thr[m])
                digit = 4'(m);
        end
        remainder = mag_reg - thr[digit][MAG_W-1:0];
    end

    assign out_free   = ~out_valid_reg | ~chr_stall;
    assign step       = active_reg & out_free;
    assign emit_digit = started_reg | (digit != '0) | (idx_reg == LAST_IDX);
    assign finishing  = step & ~neg_pending_reg & (idx_reg == LAST_IDX);
    assign load       = fifo_nonempty & (~active_reg | finishing);
    assign pop        = load;

    assign chr_valid = out_valid_reg;
    assign chr_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            mag_reg <= pop_job.mag;
        else if (step && !neg_pending_reg)
            mag_reg <= remainder;
        if (step)
        begin
            if (neg_pending_reg)
            begin
                out_data_reg.char_code <= CHAR_MINUS;
                out_data_reg.last      <= 1'b0;
            end
            else
            begin
                out_data_reg.char_code <= CHAR_ZERO + {4'd0, digit};
                out_data_reg.last      <= (idx_reg == LAST_IDX);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            neg_pending_reg <= 1'b0;
            started_reg     <= 1'b0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= step & (neg_pending_reg | emit_digit);
            if (load)
            begin
                active_reg      <= 1'b1;
                neg_pending_reg <= pop_job.neg;
                started_reg     <= 1'b0;
                idx_reg         <= '0;
            end
            else if (step)
            begin
                if (neg_pending_reg)
                    neg_pending_reg <= 1'b0;
                else
                begin
                    started_reg <= emit_digit;
                    idx_reg     <= idx_reg + IDX_W'(1);
                    if (idx_reg == LAST_IDX)
                        active_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/i2d_checker.sv =====
// Port-level checks for the converter, bound to the top level.
`timescale 1ns / 1ps

module i2d_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              chr_valid,
    input logic              chr_stall,
    input i2d_pkg::out_req_t chr_data
);
    import i2d_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && chr_stall |=> chr_valid && $stable(chr_data))
        else $error("character changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid |-> chr_data.char_code == CHAR_MINUS
                   || (chr_data.char_code >= CHAR_ZERO
                       && chr_data.char_code <= CHAR_ZERO + 8'd9))
        else $error("illegal character code");

    a_minus: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && chr_data.char_code == CHAR_MINUS |-> !chr_data.last)
        else $error("sign marked as last character");

    a_reset: assert property (@(posedge clk)
        !rst_n |-> !chr_valid)
        else $error("character valid during reset");

endmodule

bind int32_to_decimal_ascii_core i2d_checker u_i2d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr_data  (chr_data)
);

// ===== tb/int32_to_decimal_ascii_checker.sv =====
// Checker for the decimal text converter: predicts characters per request and compares them.
`timescale 1ns / 1ps

module int32_to_decimal_ascii_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  i2d_pkg::in_req_t  req_data,
    input  logic              chr_valid,
    input  logic              chr_stall,
    input  i2d_pkg::out_req_t chr_data,
    output int                fail_count,
    output int                pending
);

    localparam logic [7:0] MINUS_CODE = 8'h2D;
    localparam logic [7:0] ZERO_CODE  = 8'h30;

    i2d_pkg::out_req_t expected_chars[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic void push_decimal_text(i2d_pkg::in_req_t r);
        logic [31:0]       mag;
        logic [3:0]        digits [10];
        int                n;
        i2d_pkg::out_req_t c;
        mag = r.value;
        n   = 0;
        if (r.signed_mode && r.value[31])
        begin
            c.char_code = MINUS_CODE;
            c.last      = 1'b0;
            expected_chars.push_back(c);
            mag = ~r.value + 32'd1;
        end
        do
        begin
            digits[n] = 4'(mag % 32'd10);
            mag       = mag / 32'd10;
            n++;
        end
        while (mag != 32'd0);
        for (int i = n - 1; i >= 0; i--)
        begin
            c.char_code = ZERO_CODE + 8'(digits[i]);
            c.last      = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    always @(posedge clk)
    begin
        i2d_pkg::out_req_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                push_decimal_text(req_data);
            if (chr_valid && !chr_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected character 0x%02h last=%0b",
                                 $realtime, chr_data.char_code, chr_data.last);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (want.char_code !== chr_data.char_code || want.last !== chr_data.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                                     $realtime, want.char_code, want.last,
                                     chr_data.char_code, chr_data.last);
                    end
                end
            end
            pending = expected_chars.size();
        end
    end

endmodule

// ===== tb/int32_to_decimal_ascii_core_tb.sv =====
// Testbench top for the decimal text converter: clock, reset, request and stall stimulus, verdict.
`timescale 1ns / 1ps

module int32_to_decimal_ascii_core_tb;

    localparam int IDLE_LIMIT    = 3000;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_COUNT  = 120;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    i2d_pkg::in_req_t  req_data;
    logic              chr_valid;
    logic              chr_stall;
    i2d_pkg::out_req_t chr_data;

    int fail_count;
    int pending;
    int idle_cycles;
    bit send_quiet;
    bit recv_quiet;
    bit hold_request;

    int32_to_decimal_ascii_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr_data  (chr_data)
    );

    int32_to_decimal_ascii_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .chr_valid  (chr_valid),
        .chr_stall  (chr_stall),
        .chr_data   (chr_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (chr_valid && !chr_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_value(input logic [31:0] value, input logic smode);
        int gap;
        bit taken;
        gap = send_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{value: value, signed_mode: smode};
        do
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(posedge clk);
    endtask

    // character side: random stall per character, optional long hold
    initial
    begin
        int  n;
        bit  taken;
        chr_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                chr_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            n = recv_quiet ? 0 : $urandom_range(0, 13);
            if (n > 0)
            begin
                chr_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            chr_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                taken = chr_valid;
                @(posedge clk);
            end
            while (!taken);
        end
    end

    initial
    begin
        logic [31:0] v;
        logic        smode;
        int          kind;
        int          p10;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_data     = '0;
        idle_cycles  = 0;
        send_quiet   = 1'b0;
        recv_quiet   = 1'b0;
        hold_request = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, digit boundaries, sign handling, most negative, full unsigned range
        send_value(32'd0, 1'b0);
        send_value(32'd0, 1'b1);
        send_value(32'd1, 1'b0);
        send_value(32'd9, 1'b1);
        send_value(32'd10, 1'b0);
        send_value(32'd100, 1'b1);
        send_value(32'd999999999, 1'b0);
        send_value(32'd1000000000, 1'b1);
        send_value(32'h7FFFFFFF, 1'b0);
        send_value(32'h7FFFFFFF, 1'b1);
        send_value(32'h80000000, 1'b1);
        send_value(32'h80000000, 1'b0);
        send_value(32'h80000001, 1'b1);
        send_value(32'hFFFFFFFF, 1'b1);
        send_value(32'hFFFFFFFF, 1'b0);
        send_value(32'hFFFFFFF6, 1'b1);
        send_value(32'hAAAAAAAA, 1'b0);
        send_value(32'h55555555, 1'b1);
        send_value(32'hAAAAAAAA, 1'b1);
        send_value(32'hC4653600, 1'b0);

        // sender waits for every character
        req_valid <= 1'b0;
        wait_drained();

        // receiver holds off while requests keep coming
        send_quiet   = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 10; i++)
            send_value($urandom, 1'($urandom_range(0, 1)));
        send_quiet = 1'b0;

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i % 25 == 0)
            begin
                send_quiet = ($urandom_range(0, 3) == 0);
                recv_quiet = ($urandom_range(0, 3) == 0);
            end
            smode = 1'($urandom_range(0, 1));
            kind  = $urandom_range(0, 4);
            p10   = 1;
            for (int k = $urandom_range(0, 9); k > 0; k--)
                p10 = p10 * 10;
            case (kind)
                0: v = $urandom;
                1: v = $urandom_range(0, 9);
                2: v = 32'(p10) + 32'($urandom_range(0, 2)) - 32'd1;
                3: v = $urandom % 32'(p10);
                default:
                begin
                    v     = 32'd0 - 32'($urandom_range(1, 1000));
                    smode = 1'b1;
                end
            endcase
            send_value(v, smode);
        end
        req_valid <= 1'b0;
        send_quiet = 1'b0;
        recv_quiet = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== int32_to_decimal_ascii_core.f =====
rtl/i2d_pkg.sv
rtl/i2d_front.sv
rtl/i2d_fifo.sv
rtl/i2d_back.sv
rtl/int32_to_decimal_ascii_core.sv
rtl/i2d_checker.sv
tb/int32_to_decimal_ascii_checker.sv
tb/int32_to_decimal_ascii_core_tb.sv
